>>> hdl/modexp_pkg.sv
// Shared types and constants for the modular exponentiation block.
package modexp_pkg;

	localparam int unsigned DefaultWordWidth = 32;

	localparam logic [1:0] RegPublicExponent  = 2'd0;
	localparam logic [1:0] RegPrivateExponent = 2'd1;
	localparam logic [1:0] RegModulus         = 2'd2;

	localparam logic OpEncrypt = 1'b0;
	localparam logic OpDecrypt = 1'b1;

	typedef enum logic [1:0] {
		MUL_SQUARE = 2'd0,
		MUL_ACCUM  = 2'd1,
		MUL_REDUCE = 2'd2
	} mul_sel_t;

	typedef struct packed {
		logic     load;
		logic     mul_start;
		mul_sel_t mul_sel;
		logic     write_acc;
		logic     write_sq;
		logic     shift_exp;
	} modexp_cmd_t;

	typedef struct packed {
		logic mul_done;
		logic exp_zero;
		logic exp_lsb;
	} modexp_sts_t;

endpackage

>>> hdl/modular_exponentiation.sv
// Top level of the modular exponentiation block: registers, controller and datapath.
//
// Input channel: in_valid/in_stall carry operation and data. Operation encrypt
// raises data to public_exponent, decrypt to private_exponent, both modulo the
// modulus register (values below two act as two). A zero exponent gives 1.
// Output channel: out_valid/out_stall carry result, one per input transaction.
// Registers on the APB port: public_exponent at 0x0, private_exponent at 0x4,
// modulus at 0x8; write them only while the block is idle.
// Sequence: each modular multiply is bit-serial. An item takes one reduce of data,
// one square per exponent bit up to its top set bit and one multiply per set
// bit, with a decision state before each square and once more at the end.
// One item is in flight at a time; the shared multiplier sets the rate.
// The result is held in an output register; while out_stall is high it stays
// and no new input transaction is taken. Reset clears the registers to
// exponents 1 and modulus 2 and drops all valids.
module modular_exponentiation import modexp_pkg::*; #(
	parameter int unsigned WORD_WIDTH = DefaultWordWidth
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [3:0]            paddr,
	input  logic [31:0]           pwdata,
	output logic [31:0]           prdata,
	output logic                  pready,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic                  operation,
	input  logic [WORD_WIDTH-1:0] data,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [WORD_WIDTH-1:0] result
);

	logic [WORD_WIDTH-1:0] pub_exp_q;
	logic [WORD_WIDTH-1:0] priv_exp_q;
	logic [WORD_WIDTH-1:0] modulus_q;
	logic                  wr_en;
	logic [1:0]            reg_idx;
	modexp_cmd_t           cmd;
	modexp_sts_t           sts;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite;
	assign reg_idx = paddr[3:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pub_exp_q  <= WORD_WIDTH'(1);
			priv_exp_q <= WORD_WIDTH'(1);
			modulus_q  <= WORD_WIDTH'(2);
		end else if (wr_en && paddr[1:0] == 2'b00) begin
			unique case (reg_idx)
				RegPublicExponent:  pub_exp_q  <= pwdata[WORD_WIDTH-1:0];
				RegPrivateExponent: priv_exp_q <= pwdata[WORD_WIDTH-1:0];
				RegModulus:         modulus_q  <= pwdata[WORD_WIDTH-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			RegPublicExponent:  prdata = 32'(pub_exp_q);
			RegPrivateExponent: prdata = 32'(priv_exp_q);
			RegModulus:         prdata = 32'(modulus_q);
			default:            prdata = '0;
		endcase
	end

	modexp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	modexp_datapath #(.WordWidth(WORD_WIDTH)) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.data     (data),
		.exponent ((operation == OpDecrypt) ? priv_exp_q : pub_exp_q),
		.modulus  (modulus_q),
		.sts      (sts),
		.result   (result)
	);

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("input taken while result pending");

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(result))
		else $error("stalled result changed");

	a_load_once: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> in_stall)
		else $error("controller idle after load");

endmodule

>>> hdl/modexp_modmul.sv
// Bit-serial modular multiplier: computes a * b mod m, one multiplier bit per cycle.
module modexp_modmul import modexp_pkg::*; #(
	parameter int unsigned WordWidth = DefaultWordWidth
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [WordWidth-1:0] a,
	input  logic [WordWidth-1:0] b,
	input  logic [WordWidth-1:0] m,
	output logic                 done,
	output logic [WordWidth-1:0] product
);

	localparam int unsigned CntWidth = $clog2(WordWidth + 1);

	logic [WordWidth-1:0] acc_q;
	logic [WordWidth-1:0] a_q;
	logic [WordWidth-1:0] b_q;
	logic [CntWidth-1:0]  cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic [WordWidth+1:0] dbl;
	logic [WordWidth+1:0] red1;
	logic [WordWidth+1:0] sum;
	logic [WordWidth+1:0] red2;
	logic [WordWidth+1:0] m_ext;

	// acc holds values below m; a below m
	assign m_ext = {2'b00, m};
	assign dbl   = {1'b0, acc_q, 1'b0};
	assign red1  = (dbl >= m_ext) ? dbl - m_ext : dbl;
	assign sum   = red1 + (b_q[WordWidth-1] ? {2'b00, a_q} : '0);
	assign red2  = (sum >= m_ext) ? sum - m_ext : sum;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CntWidth'(WordWidth);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CntWidth'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= '0;
			a_q   <= a;
			b_q   <= b;
		end else if (busy_q) begin
			acc_q <= red2[WordWidth-1:0];
			b_q   <= {b_q[WordWidth-2:0], 1'b0};
		end
	end

	assign done    = done_q;
	assign product = acc_q;

endmodule

>>> hdl/modexp_datapath.sv
// Datapath: operand registers, exponent shifter and the shared modular multiplier.
module modexp_datapath import modexp_pkg::*; #(
	parameter int unsigned WordWidth = DefaultWordWidth
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  modexp_cmd_t          cmd,
	input  logic [WordWidth-1:0] data,
	input  logic [WordWidth-1:0] exponent,
	input  logic [WordWidth-1:0] modulus,
	output modexp_sts_t          sts,
	output logic [WordWidth-1:0] result
);

	logic [WordWidth-1:0] acc_q;
	logic [WordWidth-1:0] sq_q;
	logic [WordWidth-1:0] exp_q;
	logic [WordWidth-1:0] mod_q;
	logic [WordWidth-1:0] mul_a;
	logic [WordWidth-1:0] mul_b;
	logic [WordWidth-1:0] product;
	logic                 mul_done;

	always_comb begin
		case (cmd.mul_sel)
			MUL_ACCUM: begin
				mul_a = sq_q;
				mul_b = acc_q;
			end
			MUL_REDUCE: begin
				mul_a = WordWidth'(1);
				mul_b = sq_q;
			end
			default: begin
				mul_a = sq_q;
				mul_b = sq_q;
			end
		endcase
	end

	modexp_modmul #(.WordWidth(WordWidth)) u_modmul (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cmd.mul_start),
		.a       (mul_a),
		.b       (mul_b),
		.m       (mod_q),
		.done    (mul_done),
		.product (product)
	);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			acc_q <= WordWidth'(1);
			sq_q  <= data;
			exp_q <= exponent;
			mod_q <= (modulus < WordWidth'(2)) ? WordWidth'(2) : modulus;
		end else begin
			if (cmd.write_acc) acc_q <= product;
			if (cmd.write_sq)  sq_q  <= product;
			if (cmd.shift_exp) exp_q <= exp_q >> 1;
		end
	end

	assign sts.mul_done = mul_done;
	assign sts.exp_zero = (exp_q == '0);
	assign sts.exp_lsb  = exp_q[0];
	assign result       = acc_q;

endmodule

>>> hdl/modexp_ctrl.sv
// Controller: sequences reduce, multiply and square steps and runs the handshakes.
module modexp_ctrl import modexp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	output logic        out_valid,
	input  logic        out_stall,
	input  modexp_sts_t sts,
	output modexp_cmd_t cmd
);

	typedef enum logic [2:0] {
		IDLE, REDUCE, DECIDE, MUL_WAIT, SQ_WAIT, DONE
	} state_t;

	state_t      state_q;
	logic        out_valid_q;
	modexp_cmd_t cmd_q;
	logic        accept;

	assign in_stall  = (state_q != IDLE) || out_valid_q;
	assign accept    = in_valid && !in_stall;
	assign out_valid = out_valid_q;

	always_comb begin
		cmd      = cmd_q;
		cmd.load = accept;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= IDLE;
			out_valid_q <= 1'b0;
			cmd_q       <= '0;
		end else begin
			cmd_q.mul_start <= 1'b0;
			cmd_q.write_acc <= 1'b0;
			cmd_q.write_sq  <= 1'b0;
			cmd_q.shift_exp <= 1'b0;
			if (out_valid_q && !out_stall) out_valid_q <= 1'b0;
			unique case (state_q)
				IDLE: begin
					if (accept) begin
						cmd_q.mul_sel   <= MUL_REDUCE;
						cmd_q.mul_start <= 1'b1;
						state_q         <= REDUCE;
					end
				end
				REDUCE: begin
					if (sts.mul_done) begin
						cmd_q.write_sq <= 1'b1;
						state_q        <= DECIDE;
					end
				end
				DECIDE: begin
					if (sts.exp_zero) begin
						state_q <= DONE;
					end else if (sts.exp_lsb) begin
						cmd_q.mul_sel   <= MUL_ACCUM;
						cmd_q.mul_start <= 1'b1;
						state_q         <= MUL_WAIT;
					end else begin
						cmd_q.mul_sel   <= MUL_SQUARE;
						cmd_q.mul_start <= 1'b1;
						cmd_q.shift_exp <= 1'b1;
						state_q         <= SQ_WAIT;
					end
				end
				MUL_WAIT: begin
					if (sts.mul_done) begin
						cmd_q.write_acc <= 1'b1;
						cmd_q.mul_sel   <= MUL_SQUARE;
						cmd_q.mul_start <= 1'b1;
						cmd_q.shift_exp <= 1'b1;
						state_q         <= SQ_WAIT;
					end
				end
				SQ_WAIT: begin
					if (sts.mul_done) begin
						cmd_q.write_sq <= 1'b1;
						state_q        <= DECIDE;
					end
				end
				DONE: begin
					out_valid_q <= 1'b1;
					state_q     <= IDLE;
				end
				default: state_q <= IDLE;
			endcase
		end
	end

endmodule
